// ===== hw/rtl/conv_pkg.sv =====
// ----------------------------------------------------------------------------
// conv_pkg: shared types and constants of the convolution layer
// Command codes, register indexes, size defaults and the front-to-back
// job word.
// ----------------------------------------------------------------------------
package conv_pkg;

  localparam int unsigned DefMaxKernels    = 16;
  localparam int unsigned DefMaxChannels   = 8;
  localparam int unsigned DefMaxKernelSide = 7;
  localparam int unsigned DefMaxImageSide  = 32;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  typedef enum logic [1:0] {
    CMD_WEIGHT = 2'd0,
    CMD_BIAS   = 2'd1,
    CMD_PIXEL  = 2'd2,
    CMD_QUERY  = 2'd3
  } cmd_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_BORDER   = 3'd0,
    REG_KERNELS  = 3'd1,
    REG_CHANNELS = 3'd2,
    REG_KROWS    = 3'd3,
    REG_KCOLS    = 3'd4,
    REG_IROWS    = 3'd5,
    REG_ICOLS    = 3'd6
  } reg_e;

  typedef struct packed {
    logic [3:0]  kernel_index;
    logic [2:0]  channel;
    logic [4:0]  row;
    logic [4:0]  col;
    logic [15:0] value;
    cmd_e        cmd;
  } item_t;

  typedef struct packed {
    logic        [31:0] result_value;
    logic               position_invalid;
  } result_t;

  // Query job handed from the front to the back: flagged or a sweep.
  typedef struct packed {
    logic       flagged;
    logic [3:0] kidx;
    logic [4:0] row;
    logic [4:0] col;
  } job_t;

  // Clamped layer geometry, held in the front and read by the back.
  typedef struct packed {
    logic       same;
    logic [3:0] nc;
    logic [2:0] kr;
    logic [2:0] kc;
    logic [5:0] ir;
    logic [5:0] ic;
    logic [2:0] pad_r;
    logic [2:0] pad_c;
  } geom_t;

endpackage

// ===== hw/rtl/conv_if.sv =====
// ----------------------------------------------------------------------------
// conv_if: valid/ready channels
// Input item channel, result channel and configuration write channel.
// ----------------------------------------------------------------------------
interface conv_item_if;
  logic               valid;
  logic               ready;
  conv_pkg::item_t    payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface conv_result_if;
  logic               valid;
  logic               ready;
  conv_pkg::result_t  payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface conv_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [conv_pkg::CfgIdxW-1:0]  index;
  logic [conv_pkg::CfgDataW-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/conv2d_layer.sv =====
// ----------------------------------------------------------------------------
// conv2d_layer: multi-channel 2D convolution layer
// Loads weights, biases and pixels; answers queries with a saturated Q16.16
// convolution value.
// ----------------------------------------------------------------------------
// A load word is never answered. A query word is answered once; a single
// multiply-accumulate unit walks every tap of every channel for it, and a
// flagged query skips the walk. Up to two queries queue while the engine works;
// a load word waits until every earlier query has finished, so each query sees
// the stores as they were when it was taken.
// Stores come up undefined; read only entries already written.
module conv2d_layer #(
  parameter int unsigned MaxKernels    = conv_pkg::DefMaxKernels,
  parameter int unsigned MaxChannels   = conv_pkg::DefMaxChannels,
  parameter int unsigned MaxKernelSide = conv_pkg::DefMaxKernelSide,
  parameter int unsigned MaxImageSide  = conv_pkg::DefMaxImageSide
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  conv_item_if.sink     in_item,
  conv_cfg_if.sink      cfg,
  conv_result_if.source out_res
);
  import conv_pkg::*;

  geom_t       geom;
  logic        w_we, b_we, p_we;
  logic [3:0]  w_k;
  logic [2:0]  w_c, w_r, w_col;
  logic [15:0] wdata;
  logic [4:0]  p_r, p_col;
  logic        job_valid, job_ready;
  job_t        job;

  conv_front #(
    .MaxKernels(MaxKernels), .MaxChannels(MaxChannels),
    .MaxKernelSide(MaxKernelSide), .MaxImageSide(MaxImageSide)
  ) u_front (
    .clk_i, .rst_ni, .item(in_item), .cfg,
    .geom_o(geom), .w_we_o(w_we), .w_k_o(w_k), .w_c_o(w_c), .w_r_o(w_r),
    .w_col_o(w_col), .b_we_o(b_we), .p_we_o(p_we), .wdata_o(wdata),
    .p_r_o(p_r), .p_col_o(p_col),
    .job_valid_o(job_valid), .job_o(job), .job_ready_i(job_ready)
  );

  conv_back #(
    .MaxKernels(MaxKernels), .MaxChannels(MaxChannels),
    .MaxKernelSide(MaxKernelSide), .MaxImageSide(MaxImageSide)
  ) u_back (
    .clk_i, .rst_ni, .geom_i(geom),
    .w_we_i(w_we), .w_k_i(w_k), .w_c_i(w_c), .w_r_i(w_r), .w_col_i(w_col),
    .b_we_i(b_we), .p_we_i(p_we), .wdata_i(wdata), .p_r_i(p_r), .p_col_i(p_col),
    .job_valid_i(job_valid), .job_i(job), .job_ready_o(job_ready),
    .res(out_res)
  );

endmodule

// ===== hw/rtl/conv_front.sv =====
// ----------------------------------------------------------------------------
// conv_front: item intake and classification
// Holds the configuration, writes the weight, bias and pixel stores on load
// words, range-checks queries and pushes query jobs into a short queue.
// ----------------------------------------------------------------------------
module conv_front #(
  parameter int unsigned MaxKernels    = conv_pkg::DefMaxKernels,
  parameter int unsigned MaxChannels   = conv_pkg::DefMaxChannels,
  parameter int unsigned MaxKernelSide = conv_pkg::DefMaxKernelSide,
  parameter int unsigned MaxImageSide  = conv_pkg::DefMaxImageSide
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  conv_item_if.sink         item,
  conv_cfg_if.sink          cfg,
  output conv_pkg::geom_t   geom_o,
  // store write ports
  output logic              w_we_o,
  output logic [3:0]        w_k_o,
  output logic [2:0]        w_c_o,
  output logic [2:0]        w_r_o,
  output logic [2:0]        w_col_o,
  output logic              b_we_o,
  output logic              p_we_o,
  output logic [15:0]       wdata_o,
  output logic [4:0]        p_r_o,
  output logic [4:0]        p_col_o,
  // job queue
  output logic              job_valid_o,
  output conv_pkg::job_t    job_o,
  input  logic              job_ready_i
);
  import conv_pkg::*;

  localparam int unsigned QDepth = 2;

  logic       border_q;
  logic [4:0] nk_raw_q;
  logic [3:0] nc_raw_q;
  logic [2:0] kr_raw_q, kc_raw_q;
  logic [5:0] ir_raw_q, ic_raw_q;

  logic [4:0] nk;
  logic [3:0] nc;
  logic [2:0] kr, kc;
  logic [5:0] ir, ic;
  logic [5:0] out_r, out_c;

  job_t       q_mem [QDepth];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       push;
  job_t       job_new;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      border_q <= 1'b0;
      nk_raw_q <= 5'd1;
      nc_raw_q <= 4'd1;
      kr_raw_q <= 3'd3;
      kc_raw_q <= 3'd3;
      ir_raw_q <= 6'd32;
      ic_raw_q <= 6'd32;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_BORDER:   border_q <= cfg.data[0];
        REG_KERNELS:  nk_raw_q <= cfg.data[4:0];
        REG_CHANNELS: nc_raw_q <= cfg.data[3:0];
        REG_KROWS:    kr_raw_q <= cfg.data[2:0];
        REG_KCOLS:    kc_raw_q <= cfg.data[2:0];
        REG_IROWS:    ir_raw_q <= cfg.data[5:0];
        REG_ICOLS:    ic_raw_q <= cfg.data[5:0];
        default: ;
      endcase
    end
  end

  // zero counts as one, oversize counts as the maximum
  always_comb begin
    nk = (nk_raw_q == '0) ? 5'd1 : (nk_raw_q > 5'(MaxKernels)) ? 5'(MaxKernels) : nk_raw_q;
    nc = (nc_raw_q == '0) ? 4'd1 : (nc_raw_q > 4'(MaxChannels)) ? 4'(MaxChannels) : nc_raw_q;
    kr = (kr_raw_q == '0) ? 3'd1 : (kr_raw_q > 3'(MaxKernelSide)) ? 3'(MaxKernelSide) : kr_raw_q;
    kc = (kc_raw_q == '0) ? 3'd1 : (kc_raw_q > 3'(MaxKernelSide)) ? 3'(MaxKernelSide) : kc_raw_q;
    ir = (ir_raw_q == '0) ? 6'd1 : (ir_raw_q > 6'(MaxImageSide)) ? 6'(MaxImageSide) : ir_raw_q;
    ic = (ic_raw_q == '0) ? 6'd1 : (ic_raw_q > 6'(MaxImageSide)) ? 6'(MaxImageSide) : ic_raw_q;
    if (border_q) begin
      out_r = ir;
      out_c = ic;
    end else begin
      out_r = (ir >= 6'(kr)) ? ir - 6'(kr) + 6'd1 : 6'd0;
      out_c = (ic >= 6'(kc)) ? ic - 6'(kc) + 6'd1 : 6'd0;
    end
    geom_o.same  = border_q;
    geom_o.nc    = nc;
    geom_o.kr    = kr;
    geom_o.kc    = kc;
    geom_o.ir    = ir;
    geom_o.ic    = ic;
    geom_o.pad_r = border_q ? (kr - 3'd1) >> 1 : 3'd0;
    geom_o.pad_c = border_q ? (kc - 3'd1) >> 1 : 3'd0;
  end

  logic acc_item;
  // hold a load word until every earlier query is done with the stores
  assign item.ready = (cnt_q != 2'(QDepth))
                      && (item.payload.cmd == CMD_QUERY || (cnt_q == 2'd0 && job_ready_i));
  assign acc_item   = item.valid && item.ready;

  assign wdata_o = item.payload.value;
  assign w_k_o   = item.payload.kernel_index;
  assign w_c_o   = item.payload.channel;
  assign w_r_o   = item.payload.row[2:0];
  assign w_col_o = item.payload.col[2:0];
  assign p_r_o   = item.payload.row;
  assign p_col_o = item.payload.col;

  always_comb begin
    w_we_o = acc_item && item.payload.cmd == CMD_WEIGHT
             && 32'(item.payload.kernel_index) < MaxKernels
             && 32'(item.payload.channel) < MaxChannels
             && 32'(item.payload.row) < MaxKernelSide
             && 32'(item.payload.col) < MaxKernelSide;
    b_we_o = acc_item && item.payload.cmd == CMD_BIAS
             && 32'(item.payload.kernel_index) < MaxKernels;
    p_we_o = acc_item && item.payload.cmd == CMD_PIXEL
             && 32'(item.payload.channel) < MaxChannels
             && 32'(item.payload.row) < MaxImageSide
             && 32'(item.payload.col) < MaxImageSide;
  end

  assign push = acc_item && item.payload.cmd == CMD_QUERY;
  always_comb begin
    job_new.kidx    = item.payload.kernel_index;
    job_new.row     = item.payload.row;
    job_new.col     = item.payload.col;
    job_new.flagged = (5'(item.payload.kernel_index) >= nk)
                      || (6'(item.payload.row) >= out_r)
                      || (6'(item.payload.col) >= out_c);
  end

  logic pop;
  assign job_valid_o = (cnt_q != 2'd0);
  assign job_o       = q_mem[rp_q];
  assign pop         = job_valid_o && job_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) q_mem[wp_q] <= job_new;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop)  rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'(QDepth)) |-> !push) else $error("job queue overflow");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd0) |=> (cnt_q <= 2'd1)) else $error("job queue count jump");
  a_one_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({w_we_o, b_we_o, p_we_o, push})) else $error("item went two ways");
`endif

endmodule

// ===== hw/rtl/conv_back.sv =====
// ----------------------------------------------------------------------------
// conv_back: multiply-accumulate engine
// Owns the stores, sweeps channels and kernel taps of one query with one
// multiply-accumulate a cycle, saturates and holds the result word.
// ----------------------------------------------------------------------------
module conv_back #(
  parameter int unsigned MaxKernels    = conv_pkg::DefMaxKernels,
  parameter int unsigned MaxChannels   = conv_pkg::DefMaxChannels,
  parameter int unsigned MaxKernelSide = conv_pkg::DefMaxKernelSide,
  parameter int unsigned MaxImageSide  = conv_pkg::DefMaxImageSide
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  conv_pkg::geom_t   geom_i,
  input  logic              w_we_i,
  input  logic [3:0]        w_k_i,
  input  logic [2:0]        w_c_i,
  input  logic [2:0]        w_r_i,
  input  logic [2:0]        w_col_i,
  input  logic              b_we_i,
  input  logic              p_we_i,
  input  logic [15:0]       wdata_i,
  input  logic [4:0]        p_r_i,
  input  logic [4:0]        p_col_i,
  input  logic              job_valid_i,
  input  conv_pkg::job_t    job_i,
  output logic              job_ready_o,
  conv_result_if.source     res
);
  import conv_pkg::*;

  localparam int unsigned WDepth = MaxKernels * MaxChannels * MaxKernelSide * MaxKernelSide;
  localparam int unsigned PDepth = MaxChannels * MaxImageSide * MaxImageSide;
  localparam int unsigned WAw    = $clog2(WDepth);
  localparam int unsigned PAw    = $clog2(PDepth);
  localparam int unsigned BAw    = (MaxKernels > 1) ? $clog2(MaxKernels) : 1;
  localparam logic signed [47:0] SatHi = 48'sh0000_7FFF_FFFF;
  localparam logic signed [47:0] SatLo = -48'sh0000_8000_0000;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SWEEP = 5'b00010,
    ST_DRAIN = 5'b00100,
    ST_SAT   = 5'b01000,
    ST_OUT   = 5'b10000
  } state_e;

  logic signed [15:0] wmem [WDepth];
  logic signed [15:0] pmem [PDepth];
  logic signed [15:0] bmem [MaxKernels];

  logic [WAw-1:0] w_waddr, w_raddr;
  logic [PAw-1:0] p_waddr, p_raddr;

  assign w_waddr = WAw'(((32'(w_k_i) * MaxChannels + 32'(w_c_i)) * MaxKernelSide
                   + 32'(w_r_i)) * MaxKernelSide + 32'(w_col_i));
  assign p_waddr = PAw'((32'(w_c_i) * MaxImageSide + 32'(p_r_i)) * MaxImageSide
                   + 32'(p_col_i));

  state_e state_q;
  job_t   job_q;
  logic [3:0] c_q;
  logic [2:0] tr_q, tc_q;
  logic signed [47:0] acc_q;
  logic signed [15:0] w_rd_q, p_rd_q;
  logic        rd_v_q, tap_ok_q;
  logic signed [31:0] prod_q;
  logic        prod_v_q;
  logic [31:0] out_val_q;
  logic        out_flag_q;

  logic signed [7:0] pr, pc;
  logic tap_ok, last_tap;

  always_comb begin
    pr = 8'(job_q.row) + 8'(tr_q) - 8'(geom_i.pad_r);
    pc = 8'(job_q.col) + 8'(tc_q) - 8'(geom_i.pad_c);
    tap_ok = (pr >= 0) && (pr < $signed(8'(geom_i.ir)))
             && (pc >= 0) && (pc < $signed(8'(geom_i.ic)));
    w_raddr = WAw'(((32'(job_q.kidx) * MaxChannels + 32'(c_q)) * MaxKernelSide
              + 32'(tr_q)) * MaxKernelSide + 32'(tc_q));
    p_raddr = PAw'((32'(c_q) * MaxImageSide + 32'(pr[5:0])) * MaxImageSide
              + 32'(pc[5:0]));
    last_tap = (tc_q == geom_i.kc - 3'd1) && (tr_q == geom_i.kr - 3'd1)
               && (c_q == geom_i.nc - 4'd1);
  end

  // stores: one write port each; weight and pixel have a registered read port, bias is read directly
  always_ff @(posedge clk_i) begin
    if (w_we_i) wmem[w_waddr] <= wdata_i;
    w_rd_q <= wmem[w_raddr];
  end
  always_ff @(posedge clk_i) begin
    if (p_we_i) pmem[p_waddr] <= wdata_i;
    p_rd_q <= pmem[p_raddr];
  end
  always_ff @(posedge clk_i) begin
    if (b_we_i) bmem[BAw'(w_k_i)] <= wdata_i;
  end

  assign job_ready_o = (state_q == ST_IDLE);
  assign res.valid   = (state_q == ST_OUT);
  assign res.payload.result_value     = out_val_q;
  assign res.payload.position_invalid = out_flag_q;

  always_ff @(posedge clk_i) begin
    prod_q <= w_rd_q * p_rd_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      rd_v_q     <= 1'b0;
      prod_v_q   <= 1'b0;
      tap_ok_q   <= 1'b0;
      c_q        <= '0;
      tr_q       <= '0;
      tc_q       <= '0;
      out_flag_q <= 1'b0;
      out_val_q  <= '0;
      job_q      <= '0;
      acc_q      <= '0;
    end else begin
      rd_v_q   <= (state_q == ST_SWEEP) && tap_ok;
      prod_v_q <= rd_v_q;
      tap_ok_q <= tap_ok;
      if (prod_v_q) acc_q <= acc_q + 48'(prod_q);
      unique case (state_q)
        ST_IDLE: begin
          if (job_valid_i) begin
            job_q <= job_i;
            c_q   <= '0;
            tr_q  <= '0;
            tc_q  <= '0;
            acc_q <= 48'($signed(bmem[BAw'(job_i.kidx)])) <<< 8;
            if (job_i.flagged) begin
              out_val_q  <= '0;
              out_flag_q <= 1'b1;
              state_q    <= ST_OUT;
            end else begin
              state_q <= ST_SWEEP;
            end
          end
        end
        ST_SWEEP: begin
          // advance column, then row, then channel
          if (last_tap) begin
            state_q <= ST_DRAIN;
          end else if (tc_q == geom_i.kc - 3'd1) begin
            tc_q <= '0;
            if (tr_q == geom_i.kr - 3'd1) begin
              tr_q <= '0;
              c_q  <= c_q + 4'd1;
            end else begin
              tr_q <= tr_q + 3'd1;
            end
          end else begin
            tc_q <= tc_q + 3'd1;
          end
        end
        ST_DRAIN: begin
          if (!rd_v_q && !prod_v_q) state_q <= ST_SAT;
        end
        ST_SAT: begin
          out_flag_q <= 1'b0;
          if (acc_q > SatHi)      out_val_q <= 32'h7FFF_FFFF;
          else if (acc_q < SatLo) out_val_q <= 32'h8000_0000;
          else                    out_val_q <= acc_q[31:0];
          state_q <= ST_OUT;
        end
        ST_OUT: begin
          if (res.ready) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT && !res.ready) |=> (state_q == ST_OUT && $stable(out_val_q)))
    else $error("result dropped");
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SAT) |-> (!rd_v_q && !prod_v_q)) else $error("saturating early");
  a_flag_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT && out_flag_q) |-> (out_val_q == '0)) else $error("flag with value");
  a_tap_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_v_q |-> tap_ok_q) else $error("bad tap read");
`endif

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: conv2d_layer check
// Loads weights, biases and pixels, asks for output values under several layer
// geometries and both border modes, and compares each answer with a local
// convolution predictor. Every store entry a query reads is loaded first.
// ----------------------------------------------------------------------------
module testbench;
  import conv_pkg::*;

  localparam int KSide = 7;
  localparam int ISide = 32;
  localparam int Drain = 450;
  localparam int QuietLimit = 5000;
  localparam int Items = 2000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  conv_item_if   in_ch();
  conv_cfg_if    cfg_ch();
  conv_result_if res_ch();

  conv2d_layer dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_item (in_ch.sink),
    .cfg     (cfg_ch.sink),
    .out_res (res_ch.source)
  );

  always #10 clk_i = ~clk_i;

  // predictor state
  logic signed [15:0] weight_mem [16*8*KSide*KSide];
  logic signed [15:0] bias_mem [16];
  logic signed [15:0] pixel_mem [8*ISide*ISide];
  bit weight_set [16*8*KSide*KSide];
  bit bias_set [16];
  bit pixel_set [8*ISide*ISide];
  logic [31:0] regs [7];

  result_t pending_results[$];
  int  errors = 0;
  bit  calm = 1'b0;
  int  quiet = 0;
  int  items_sent = 0;

  function automatic int clamp(logic [31:0] v, int hi);
    if (v < 1) return 1;
    return (v > hi) ? hi : int'(v);
  endfunction

  function automatic int w_addr(int k, int c, int r, int q);
    return ((k * 8 + c) * KSide + r) * KSide + q;
  endfunction

  function automatic int p_addr(int c, int r, int q);
    return (c * ISide + r) * ISide + q;
  endfunction

  function automatic int out_extent(int img, int ker, bit same);
    if (same) return img;
    return (img >= ker) ? img - ker + 1 : 0;
  endfunction

  // Convolution value for one query under the current geometry.
  function automatic result_t convolve(int k, int r, int q);
    result_t res;
    longint acc;
    int nk, nc, kr, kc, ir, ic, pr, pc, pad_r, pad_c;
    bit same;
    same = regs[REG_BORDER][0];
    nk = clamp(regs[REG_KERNELS], 16);
    nc = clamp(regs[REG_CHANNELS], 8);
    kr = clamp(regs[REG_KROWS], KSide);
    kc = clamp(regs[REG_KCOLS], KSide);
    ir = clamp(regs[REG_IROWS], ISide);
    ic = clamp(regs[REG_ICOLS], ISide);
    pad_r = same ? (kr - 1) / 2 : 0;
    pad_c = same ? (kc - 1) / 2 : 0;
    res.result_value = '0;
    res.position_invalid = 1'b1;
    if (k >= nk || r >= out_extent(ir, kr, same) || q >= out_extent(ic, kc, same))
      return res;
    acc = longint'(bias_mem[k]) * 256;
    for (int c = 0; c < nc; c++)
      for (int tr = 0; tr < kr; tr++)
        for (int tc = 0; tc < kc; tc++) begin
          pr = r + tr - pad_r;
          pc = q + tc - pad_c;
          if (pr >= 0 && pr < ir && pc >= 0 && pc < ic)
            acc += longint'(weight_mem[w_addr(k, c, tr, tc)]) *
                   longint'(pixel_mem[p_addr(c, pr, pc)]);
        end
    if (acc > 64'sd2147483647) acc = 64'sd2147483647;
    else if (acc < -64'sd2147483648) acc = -64'sd2147483648;
    res.result_value = acc[31:0];
    res.position_invalid = 1'b0;
    return res;
  endfunction

  // Send one word; update the stores or queue the answer once accepted.
  task automatic send_word(cmd_e cmd, int k, int c, int r, int q, logic [15:0] v);
    item_t it;
    it.cmd = cmd;
    it.kernel_index = k[3:0];
    it.channel = c[2:0];
    it.row = r[4:0];
    it.col = q[4:0];
    it.value = v;
    if (!calm && $urandom_range(99) < 30) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.payload <= it;
    @(negedge clk_i);
    while (!in_ch.ready) @(negedge clk_i);
    @(posedge clk_i);
    items_sent++;
    case (cmd)
      CMD_WEIGHT: if (r < KSide && q < KSide) begin
        weight_mem[w_addr(k, c, r, q)] = v;
        weight_set[w_addr(k, c, r, q)] = 1'b1;
      end
      CMD_BIAS: begin
        bias_mem[k] = v;
        bias_set[k] = 1'b1;
      end
      CMD_PIXEL: begin
        pixel_mem[p_addr(c, r, q)] = v;
        pixel_set[p_addr(c, r, q)] = 1'b1;
      end
      default: pending_results = {pending_results, convolve(k, r, q)};
    endcase
  endtask

  task automatic hold_input();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Wait until every answer is back and any trailing load has settled.
  task automatic wait_idle();
    hold_input();
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (Drain) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_e idx, logic [31:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= data;
    @(negedge clk_i);
    while (!cfg_ch.ready) @(negedge clk_i);
    @(posedge clk_i);
    cfg_ch.valid <= 1'b0;
    case (idx)
      REG_BORDER:   regs[idx] = data & 32'h1;
      REG_KERNELS:  regs[idx] = data & 32'h1f;
      REG_CHANNELS: regs[idx] = data & 32'hf;
      REG_KROWS, REG_KCOLS: regs[idx] = data & 32'h7;
      default:      regs[idx] = data & 32'h3f;
    endcase
  endtask

  task automatic set_geometry(int mode, int nk, int nc, int kr, int kc, int ir, int ic);
    wait_idle();
    write_reg(REG_BORDER, mode);
    write_reg(REG_KERNELS, nk);
    write_reg(REG_CHANNELS, nc);
    write_reg(REG_KROWS, kr);
    write_reg(REG_KCOLS, kc);
    write_reg(REG_IROWS, ir);
    write_reg(REG_ICOLS, ic);
  endtask

  // Load every entry the current geometry can read that is still unwritten.
  task automatic fill_missing();
    int nk, nc, kr, kc, ir, ic;
    nk = clamp(regs[REG_KERNELS], 16);
    nc = clamp(regs[REG_CHANNELS], 8);
    kr = clamp(regs[REG_KROWS], KSide);
    kc = clamp(regs[REG_KCOLS], KSide);
    ir = clamp(regs[REG_IROWS], ISide);
    ic = clamp(regs[REG_ICOLS], ISide);
    for (int k = 0; k < nk; k++) begin
      if (!bias_set[k]) send_word(CMD_BIAS, k, 0, 0, 0, 16'($urandom));
      for (int c = 0; c < nc; c++)
        for (int r = 0; r < kr; r++)
          for (int q = 0; q < kc; q++)
            if (!weight_set[w_addr(k, c, r, q)])
              send_word(CMD_WEIGHT, k, c, r, q, 16'($urandom));
    end
    for (int c = 0; c < nc; c++)
      for (int r = 0; r < ir; r++)
        for (int q = 0; q < ic; q++)
          if (!pixel_set[p_addr(c, r, q)])
            send_word(CMD_PIXEL, 0, c, r, q, 16'($urandom));
  endtask

  // Load only the unwritten entries that one query will read.
  task automatic fill_query(int k, int r, int q);
    int nk, nc, kr, kc, ir, ic, pr, pc, pad_r, pad_c;
    bit same;
    same = regs[REG_BORDER][0];
    nk = clamp(regs[REG_KERNELS], 16);
    nc = clamp(regs[REG_CHANNELS], 8);
    kr = clamp(regs[REG_KROWS], KSide);
    kc = clamp(regs[REG_KCOLS], KSide);
    ir = clamp(regs[REG_IROWS], ISide);
    ic = clamp(regs[REG_ICOLS], ISide);
    pad_r = same ? (kr - 1) / 2 : 0;
    pad_c = same ? (kc - 1) / 2 : 0;
    if (k >= nk || r >= out_extent(ir, kr, same) || q >= out_extent(ic, kc, same))
      return;
    if (!bias_set[k]) send_word(CMD_BIAS, k, 0, 0, 0, 16'($urandom));
    for (int c = 0; c < nc; c++)
      for (int tr = 0; tr < kr; tr++)
        for (int tc = 0; tc < kc; tc++) begin
          pr = r + tr - pad_r;
          pc = q + tc - pad_c;
          if (pr >= 0 && pr < ir && pc >= 0 && pc < ic) begin
            if (!weight_set[w_addr(k, c, tr, tc)])
              send_word(CMD_WEIGHT, k, c, tr, tc, 16'($urandom));
            if (!pixel_set[p_addr(c, pr, pc)])
              send_word(CMD_PIXEL, 0, c, pr, pc, 16'($urandom));
          end
        end
  endtask

  task automatic query_random();
    int nk, kr, kc, orows, ocols, k, r, q;
    bit same;
    same = regs[REG_BORDER][0];
    nk = clamp(regs[REG_KERNELS], 16);
    kr = clamp(regs[REG_KROWS], KSide);
    kc = clamp(regs[REG_KCOLS], KSide);
    orows = out_extent(clamp(regs[REG_IROWS], ISide), kr, same);
    ocols = out_extent(clamp(regs[REG_ICOLS], ISide), kc, same);
    k = ($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(nk - 1);
    r = (orows == 0 || $urandom_range(9) == 0) ? $urandom_range(31) : $urandom_range(orows - 1);
    q = (ocols == 0 || $urandom_range(9) == 0) ? $urandom_range(31) : $urandom_range(ocols - 1);
    fill_query(k, r, q);
    send_word(CMD_QUERY, k, $urandom_range(7), r, q, 16'($urandom));
  endtask

  // Extreme values, edges of the output and flagged positions at reset geometry.
  task automatic test_reset_geometry();
    send_word(CMD_BIAS, 0, 0, 0, 0, 16'h7fff);
    fill_query(0, 0, 0);
    fill_query(0, 29, 29);
    send_word(CMD_WEIGHT, 0, 0, 0, 0, 16'h8000);
    send_word(CMD_WEIGHT, 0, 0, 2, 2, 16'h7fff);
    send_word(CMD_PIXEL, 0, 7, 31, 31, 16'hffff);
    send_word(CMD_QUERY, 0, 0, 0, 0, 16'h0);
    send_word(CMD_QUERY, 0, 0, 29, 29, 16'hffff);
    send_word(CMD_QUERY, 0, 0, 30, 0, 16'h0);
    send_word(CMD_QUERY, 0, 0, 0, 31, 16'h0);
    send_word(CMD_QUERY, 15, 7, 31, 31, 16'h0);
  endtask

  // Large weights on large pixels drive the sum past both limits.
  task automatic test_saturation();
    set_geometry(1, 2, 1, 3, 3, 4, 4);
    fill_missing();
    hold_input();
    while (pending_results.size() != 0) @(posedge clk_i);
    for (int r = 0; r < 3; r++)
      for (int q = 0; q < 3; q++) begin
        send_word(CMD_WEIGHT, 0, 0, r, q, 16'h7fff);
        send_word(CMD_WEIGHT, 1, 0, r, q, 16'h8000);
      end
    for (int r = 0; r < 4; r++)
      for (int q = 0; q < 4; q++) send_word(CMD_PIXEL, 0, 0, r, q, 16'h7fff);
    send_word(CMD_QUERY, 0, 0, 1, 1, 16'h0);
    send_word(CMD_QUERY, 1, 0, 1, 1, 16'h0);
    send_word(CMD_QUERY, 0, 0, 0, 3, 16'h0);
  endtask

  // Weight taps beyond the largest kernel are dropped.
  task automatic test_ignored_loads();
    send_word(CMD_WEIGHT, 0, 0, 7, 0, 16'h1234);
    send_word(CMD_WEIGHT, 0, 0, 0, 31, 16'h4321);
    send_word(CMD_WEIGHT, 15, 7, 31, 7, 16'hffff);
    hold_input();
    while (pending_results.size() != 0) @(posedge clk_i);
    send_word(CMD_QUERY, 0, 0, 0, 0, 16'h0);
  endtask

  // Size registers written as zero or beyond range, and a kernel that
  // outgrows the image so that every valid-mode query is flagged.
  task automatic test_register_extremes();
    set_geometry(0, 0, 0, 0, 0, 0, 0);
    fill_missing();
    send_word(CMD_QUERY, 0, 0, 0, 0, 16'h0);
    send_word(CMD_QUERY, 1, 0, 0, 0, 16'h0);
    set_geometry(1, 31, 15, 7, 7, 63, 63);
    fill_query(15, 0, 0);
    send_word(CMD_QUERY, 15, 0, 0, 0, 16'h0);
    set_geometry(0, 16, 2, 7, 6, 4, 5);
    send_word(CMD_QUERY, 0, 0, 0, 0, 16'h0);
    set_geometry(1, 3, 2, 4, 2, 5, 3);
    fill_missing();
    for (int r = 0; r < 5; r++) send_word(CMD_QUERY, 2, 0, r, r % 3, 16'h0);
    set_geometry(1, 16, 8, 7, 7, 32, 32);
    fill_query(15, 0, 0);
    fill_query(7, 31, 31);
    send_word(CMD_QUERY, 15, 0, 0, 0, 16'h0);
    send_word(CMD_QUERY, 7, 0, 31, 31, 16'h0);
  endtask

  task automatic test_random();
    int phase_len, nk, nc, kr, kc;
    while (items_sent < Items) begin
      if ($urandom_range(3) == 0) set_geometry($urandom_range(1), $urandom_range(16, 1),
          $urandom_range(8, 1), $urandom_range(7, 1), $urandom_range(7, 1),
          $urandom_range(32, 1), $urandom_range(32, 1));
      else set_geometry($urandom_range(1), $urandom_range(4, 1), $urandom_range(2, 1),
          $urandom_range(3, 1), $urandom_range(3, 1), $urandom_range(8, 1), $urandom_range(8, 1));
      calm = ($urandom_range(4) == 0);
      nk = clamp(regs[REG_KERNELS], 16);
      nc = clamp(regs[REG_CHANNELS], 8);
      kr = clamp(regs[REG_KROWS], KSide);
      kc = clamp(regs[REG_KCOLS], KSide);
      phase_len = $urandom_range(150, 40);
      for (int i = 0; i < phase_len && items_sent < Items; i++) begin
        if ($urandom_range(2) == 0) begin
          // stores stay untouched while queries are in flight
          hold_input();
          while (pending_results.size() != 0) @(posedge clk_i);
          case ($urandom_range(3))
            0: send_word(CMD_WEIGHT, $urandom_range(nk - 1), $urandom_range(nc - 1),
                   $urandom_range(kr - 1), $urandom_range(kc - 1), 16'($urandom));
            1: send_word(CMD_BIAS, $urandom_range(nk - 1), 0, 0, 0, 16'($urandom));
            2: send_word(CMD_PIXEL, 0, $urandom_range(nc - 1),
                   $urandom_range(clamp(regs[REG_IROWS], ISide) - 1),
                   $urandom_range(clamp(regs[REG_ICOLS], ISide) - 1), 16'($urandom));
            default: send_word(CMD_WEIGHT, $urandom_range(15), $urandom_range(7),
                   $urandom_range(31, 7), $urandom_range(31), 16'($urandom));
          endcase
        end else begin
          query_random();
        end
      end
      calm = 1'b0;
    end
  endtask

  // Take each result word and compare with the oldest expected answer.
  always @(negedge clk_i) begin
    result_t want;
    if (res_ch.valid && res_ch.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result value=%h flag=%b", $time,
                 res_ch.payload.result_value, res_ch.payload.position_invalid);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (res_ch.payload.result_value !== want.result_value) begin
          $display("%0t: result_value expected %h actual %h", $time,
                   want.result_value, res_ch.payload.result_value);
          errors++;
        end
        if (res_ch.payload.position_invalid !== want.position_invalid) begin
          $display("%0t: position_invalid expected %b actual %b", $time,
                   want.position_invalid, res_ch.payload.position_invalid);
          errors++;
        end
      end
    end
    if ((res_ch.valid && res_ch.ready) || (in_ch.valid && in_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready) || !rst_ni) quiet = 0;
    else quiet++;
    if (quiet >= QuietLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    res_ch.ready <= calm ? 1'b1 : ($urandom_range(99) >= 30);
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.payload = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    res_ch.ready = 1'b0;
    regs[REG_BORDER] = 0;
    regs[REG_KERNELS] = 1;
    regs[REG_CHANNELS] = 1;
    regs[REG_KROWS] = 3;
    regs[REG_KCOLS] = 3;
    regs[REG_IROWS] = 32;
    regs[REG_ICOLS] = 32;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_geometry();
    test_saturation();
    test_ignored_loads();
    test_register_extremes();
    test_random();
    wait_idle();
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
hw/rtl/conv_pkg.sv
hw/rtl/conv_if.sv
hw/rtl/conv_front.sv
hw/rtl/conv_back.sv
hw/rtl/conv2d_layer.sv
tb/sv/testbench.sv
